>>> rtl/shabs_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by shabs_sched, shabs_round and sha256_byte_stream_hasher; depends on nothing.
`timescale 1ns / 1ps

package shabs_pkg;

    localparam int WORD_W     = 32;
    localparam int LINE_W     = 512;
    localparam int LEN_W      = 64;
    localparam int FILL_W     = 6;
    localparam int ROUND_W    = 6;
    localparam int PART_W     = 2;
    localparam int DIGEST_W   = 64;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [FILL_W-1:0] LEN_OFFSET = FILL_W'(56);
    localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(63);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(63);
    localparam logic [PART_W-1:0] PART_LAST  = PART_W'(3);
    localparam logic [LEN_W-1:0] BITS_PER_BLOCK = LEN_W'(512);

    localparam logic [0:0] OP_ABSORB = 1'b0;
    localparam logic [0:0] OP_FINISH = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } shabs_round_ctl_t;

    typedef struct packed {
        logic shift_byte;
        logic shift_word;
    } shabs_sched_ctl_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic word_t round_const(input logic [ROUND_W-1:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/shabs_sched.sv
// Message block line and rolling schedule: 512-bit shift line filled a byte at a time,
// then advanced a word per round. Depends on shabs_pkg.
`timescale 1ns / 1ps

module shabs_sched (
    input  logic                    clk,
    input  shabs_pkg::shabs_sched_ctl_t ctl,
    input  logic [7:0]              byte_in,
    output shabs_pkg::word_t        w_cur
);
    import shabs_pkg::*;

    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    word_t             w_new;

    // word j of the line sits at bits [LINE_W-1-WORD_W*j -: WORD_W]
    assign w_cur = line_reg[LINE_W-1 -: WORD_W];

    assign w_new = small_sigma1(line_reg[LINE_W-1-WORD_W*14 -: WORD_W])
                 + line_reg[LINE_W-1-WORD_W*9 -: WORD_W]
                 + small_sigma0(line_reg[LINE_W-1-WORD_W*1 -: WORD_W])
                 + line_reg[LINE_W-1 -: WORD_W];

    always_comb
    begin
        line_next = line_reg;
        if (ctl.shift_byte)
        begin
            line_next = {line_reg[LINE_W-9:0], byte_in};
        end
        else if (ctl.shift_word)
        begin
            line_next = {line_reg[LINE_W-WORD_W-1:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

endmodule

>>> rtl/shabs_round.sv
// Working variables, chain value and the shared SHA-256 round unit.
// Depends on shabs_pkg.
`timescale 1ns / 1ps

module shabs_round (
    input  logic                        clk,
    input  logic                        rst_n,
    input  shabs_pkg::shabs_round_ctl_t ctl,
    input  shabs_pkg::word_t            w_in,
    input  logic [shabs_pkg::ROUND_W-1:0] round_idx,
    output logic [7:0][shabs_pkg::WORD_W-1:0] chain
);
    import shabs_pkg::*;

    logic [7:0][WORD_W-1:0] chain_reg;
    logic [7:0][WORD_W-1:0] chain_next;
    logic [7:0][WORD_W-1:0] work_reg;
    logic [7:0][WORD_W-1:0] work_next;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign chain = chain_reg;

    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + round_const(round_idx) + w_in;
    assign t2  = big_sigma0(work_reg[0]) + maj;

    always_comb
    begin
        work_next  = work_reg;
        chain_next = chain_reg;
        if (ctl.load)
        begin
            work_next = chain_reg;
        end
        else if (ctl.step)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
        if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = init_hash(3'(i));
            end
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level: sequencer, length and fill counters, digest output.
// Depends on shabs_pkg, shabs_sched and shabs_round.
`timescale 1ns / 1ps
//
// Usage: send message bytes on the input channel with operation = absorb, then one
// word with operation = finish. Four digest words follow on the output channel,
// part_index 0 to 3, big-endian, last_part high on the fourth.
// Throughput: absorb words are taken while in_ready is high; the word that completes a 64-byte
// block starts its compression (64 rounds on the single round unit plus one chain add),
// during which in_ready is low and no further bytes are taken.
// Finish: the padding is shifted in one byte per cycle (64 minus the pending
// bytes), then the block is compressed; with 56 or more bytes pending a second
// block of 64 pad bytes is shifted in and compressed. The digest is then
// offered one word per accepted cycle.
// Stall: the digest word holds while out_ready is low; no input is taken until all
// four words are delivered. The chain value then returns to the initial hash.
// Reset: asynchronous, active low; clears the sequencer and counters, sets the chain value to the initial hash.
//

module sha256_byte_stream_hasher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [7:0]                        data_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [shabs_pkg::DIGEST_W-1:0]    digest_part,
    output logic [shabs_pkg::PART_W-1:0]      part_index,
    output logic                              last_part
);
    import shabs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [ROUND_W-1:0]   round_reg;
    logic [ROUND_W-1:0]   round_next;
    logic [LEN_W-1:0]     bits_reg;
    logic [LEN_W-1:0]     bits_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [PART_W-1:0]    part_reg;
    logic [PART_W-1:0]    part_next;
    logic                 finishing_reg;
    logic                 finishing_next;
    logic                 mark_reg;
    logic                 mark_next;
    logic                 len_ok_reg;
    logic                 len_ok_next;

    shabs_sched_ctl_t     sched_ctl;
    shabs_round_ctl_t     round_ctl;
    logic [7:0]           byte_mux;
    word_t                w_cur;
    logic [7:0][WORD_W-1:0] chain;
    logic                 len_slot;

    shabs_sched u_sched (
        .clk     (clk),
        .ctl     (sched_ctl),
        .byte_in (byte_mux),
        .w_cur   (w_cur)
    );

    shabs_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (round_ctl),
        .w_in      (w_cur),
        .round_idx (round_reg),
        .chain     (chain)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign part_index = part_reg;
    assign last_part  = (part_reg == PART_LAST);

    always_comb
    begin
        case (part_reg)
            2'd0:    digest_part = {chain[0], chain[1]};
            2'd1:    digest_part = {chain[2], chain[3]};
            2'd2:    digest_part = {chain[4], chain[5]};
            default: digest_part = {chain[6], chain[7]};
        endcase
    end

    assign len_slot = len_ok_reg && !mark_reg && (fill_reg inside {[LEN_OFFSET:FILL_LAST]});

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        bits_next      = bits_reg;
        len_next       = len_reg;
        part_next      = part_reg;
        finishing_next = finishing_reg;
        mark_next      = mark_reg;
        len_ok_next    = len_ok_reg;
        sched_ctl      = '0;
        round_ctl      = '0;
        byte_mux       = data_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_ABSORB)
                    begin
                        sched_ctl.shift_byte = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                        if (fill_reg == FILL_LAST)
                        begin
                            round_ctl.load = 1'b1;
                            round_next     = '0;
                            state_next     = ST_COMP;
                        end
                    end
                    else
                    begin
                        finishing_next = 1'b1;
                        mark_next      = 1'b1;
                        len_ok_next    = (fill_reg < LEN_OFFSET);
                        len_next       = bits_reg + {{(LEN_W-FILL_W-3){1'b0}}, fill_reg, 3'b000};
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                sched_ctl.shift_byte = 1'b1;
                if (mark_reg)
                begin
                    byte_mux = PAD_MARK;
                end
                else if (len_slot)
                begin
                    byte_mux = len_reg[LEN_W-1 -: 8];
                    len_next = {len_reg[LEN_W-9:0], 8'h00};
                end
                else
                begin
                    byte_mux = 8'h00;
                end
                mark_next = 1'b0;
                fill_next = fill_reg + FILL_W'(1);
                if (fill_reg == FILL_LAST)
                begin
                    round_ctl.load = 1'b1;
                    round_next     = '0;
                    state_next     = ST_COMP;
                end
            end
            ST_COMP:
            begin
                round_ctl.step       = 1'b1;
                sched_ctl.shift_word = 1'b1;
                round_next           = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                round_ctl.fold = 1'b1;
                if (!finishing_reg)
                begin
                    bits_next  = bits_reg + BITS_PER_BLOCK;
                    state_next = ST_IDLE;
                end
                else if (len_ok_reg)
                begin
                    part_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (part_reg == PART_LAST)
                    begin
                        round_ctl.init = 1'b1;
                        bits_next      = '0;
                        finishing_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        part_next = part_reg + PART_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            round_reg     <= '0;
            bits_reg      <= '0;
            len_reg       <= '0;
            part_reg      <= '0;
            finishing_reg <= 1'b0;
            mark_reg      <= 1'b0;
            len_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            bits_reg      <= bits_next;
            len_reg       <= len_next;
            part_reg      <= part_next;
            finishing_reg <= finishing_next;
            mark_reg      <= mark_next;
            len_ok_reg    <= len_ok_next;
        end
    end

endmodule

>>> bench/tb.sv
// Self-checking bench for sha256_byte_stream_hasher: byte messages in, four digest words out.
// Computes every digest with its own SHA-256 model and checks each word against it.
// Depends on shabs_pkg and the hasher RTL.
`timescale 1ns / 1ps

module tb;
    import shabs_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 40;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_PCT     = 36;
    localparam int QUIET_FROM   = 150;
    localparam int QUIET_TO     = 230;
    localparam int TARGET_WORDS = 270;
    localparam int MIN_DIGESTS  = 12;

    typedef struct {
        logic       op;
        logic [7:0] dat;
        bit         hold_for_idle;
    } msg_word_t;

    typedef struct {
        logic [DIGEST_W-1:0] value;
        logic [PART_W-1:0]   idx;
        logic                last;
    } digest_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                operation = OP_ABSORB;
    logic [7:0]          data_byte = 8'h00;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [DIGEST_W-1:0] digest_part;
    logic [PART_W-1:0]   part_index;
    logic                last_part;

    msg_word_t    byte_feed[$];
    digest_word_t digest_due[$];
    digest_word_t want;

    logic [31:0] hash_state [0:7];
    logic [63:0] bits_done;
    logic [7:0]  blk_buf [0:63];
    int          fill_cnt;

    logic [31:0] sha_iv [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] sha_k [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    int boundary_lens [0:7] = '{55, 56, 57, 63, 64, 65, 119, 120};

    int  words_sent = 0;
    int  parts_due = 0;
    int  parts_out = 0;
    int  finishes_taken = 0;
    int  stall_left = 0;
    bit  stall_used = 1'b0;
    int  cycle_cnt = 0;
    int  errors = 0;
    int  finishes_queued = 0;
    int  pick;
    int  msg_len;

    logic quiet;
    logic drained;

    assign quiet = (words_sent >= QUIET_FROM) && (words_sent < QUIET_TO);
    assign drained = (parts_due == parts_out) && !(in_valid && operation == OP_FINISH);

    sha256_byte_stream_hasher u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_part (digest_part),
        .part_index  (part_index),
        .last_part   (last_part)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void start_message();
        for (int j = 0; j < 8; j++)
        begin
            hash_state[j] = sha_iv[j];
        end
        bits_done = '0;
        fill_cnt = 0;
    endfunction

    function automatic void compress_chunk();
        logic [31:0] w [0:63];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int r = 0; r < 16; r++)
        begin
            w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
        end
        for (int r = 16; r < 64; r++)
        begin
            s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + sha_k[r] + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void track_word(input logic op, input logic [7:0] dat);
        logic [63:0]  total;
        int           i;
        digest_word_t dw;
        if (op == OP_ABSORB)
        begin
            blk_buf[fill_cnt] = dat;
            fill_cnt++;
            if (fill_cnt == 64)
            begin
                compress_chunk();
                bits_done += BITS_PER_BLOCK;
                fill_cnt = 0;
            end
        end
        else
        begin
            total = bits_done + 64'(fill_cnt) * 64'd8;
            blk_buf[fill_cnt] = PAD_MARK;
            i = fill_cnt + 1;
            if (i > int'(LEN_OFFSET))
            begin
                for (; i < 64; i++) blk_buf[i] = 8'h00;
                compress_chunk();
                i = 0;
            end
            for (; i < int'(LEN_OFFSET); i++) blk_buf[i] = 8'h00;
            for (int k = 0; k < 8; k++)
            begin
                blk_buf[int'(LEN_OFFSET) + k] = total[63 - 8*k -: 8];
            end
            compress_chunk();
            for (int k = 0; k < 4; k++)
            begin
                dw.value = {hash_state[2*k], hash_state[2*k+1]};
                dw.idx   = PART_W'(k);
                dw.last  = (PART_W'(k) == PART_LAST);
                digest_due.push_back(dw);
            end
            start_message();
        end
    endfunction

    task automatic queue_word(input logic op, input logic [7:0] dat, input bit hold);
        msg_word_t mw;
        mw.op = op;
        mw.dat = dat;
        mw.hold_for_idle = hold;
        byte_feed.push_back(mw);
        if (op == OP_FINISH) finishes_queued++;
    endtask

    task automatic queue_message(input int len, input bit hold);
        for (int n = 0; n < len; n++)
        begin
            queue_word(OP_ABSORB, 8'($urandom_range(255)), hold && n == 0);
        end
        queue_word(OP_FINISH, 8'($urandom_range(255)), hold && len == 0);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            operation  <= OP_ABSORB;
            data_byte  <= 8'h00;
            words_sent <= 0;
            parts_due  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_word(operation, data_byte);
                words_sent <= words_sent + 1;
                if (operation == OP_FINISH) parts_due <= parts_due + 4;
            end
            if (!in_valid || in_ready)
            begin
                if (byte_feed.size() != 0 && !(byte_feed[0].hold_for_idle && !drained)
                    && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid  <= 1'b1;
                    operation <= byte_feed[0].op;
                    data_byte <= byte_feed[0].dat;
                    void'(byte_feed.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random backpressure plus one long hold after the third digest request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            stall_left     <= 0;
            stall_used     <= 1'b0;
            finishes_taken <= 0;
        end
        else
        begin
            if (in_valid && in_ready && operation == OP_FINISH)
                finishes_taken <= finishes_taken + 1;
            if (!stall_used && finishes_taken == 3)
            begin
                stall_left <= LONG_HOLD;
                stall_used <= 1'b1;
                out_ready  <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            parts_out <= parts_out + 1;
            if (digest_due.size() == 0)
            begin
                $display("%0t: digest word with none expected: expected none actual %h/%0d/%b",
                         $time, digest_part, part_index, last_part);
                errors++;
            end
            else
            begin
                want = digest_due.pop_front();
                if (digest_part !== want.value)
                begin
                    $display("%0t: digest_part expected %h actual %h",
                             $time, want.value, digest_part);
                    errors++;
                end
                if (part_index !== want.idx)
                begin
                    $display("%0t: part_index expected %0d actual %0d",
                             $time, want.idx, part_index);
                    errors++;
                end
                if (last_part !== want.last)
                begin
                    $display("%0t: last_part expected %b actual %b",
                             $time, want.last, last_part);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        start_message();

        // empty message, message touching every data bit, back-to-back finish
        queue_word(OP_FINISH, 8'hff, 1'b0);
        queue_word(OP_ABSORB, 8'h00, 1'b0);
        queue_word(OP_ABSORB, 8'hff, 1'b0);
        queue_word(OP_ABSORB, 8'h80, 1'b0);
        queue_word(OP_ABSORB, 8'h55, 1'b0);
        queue_word(OP_FINISH, 8'h00, 1'b0);
        queue_word(OP_FINISH, 8'haa, 1'b0);
        queue_word(OP_ABSORB, 8'haa, 1'b0);
        queue_word(OP_FINISH, 8'h55, 1'b0);

        // long tail, exact block
        queue_message(56, 1'b1);
        queue_message(64, 1'b0);

        while (byte_feed.size() < TARGET_WORDS || finishes_queued < MIN_DIGESTS)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                msg_len = $urandom_range(6);
            else if (pick < 75)
                msg_len = $urandom_range(40, 7);
            else
                msg_len = boundary_lens[$urandom_range(7)];
            queue_message(msg_len, $urandom_range(7) == 0);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (byte_feed.size() != 0 || in_valid || digest_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/shabs_pkg.sv
rtl/shabs_sched.sv
rtl/shabs_round.sv
rtl/sha256_byte_stream_hasher.sv
bench/tb.sv
